// ===== rtl/gamepad_servo_jog_integrator_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the gamepad servo jog integrator
// Concurrent checks, removed when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_SERVO_JOG_INTEGRATOR_CORE_MACROS_SVH
`define GAMEPAD_SERVO_JOG_INTEGRATOR_CORE_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/gsji_pkg.sv =====
// ----------------------------------------------------------------------------
// gsji_pkg
// Shared constants, types and helper functions of the servo jog integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package gsji_pkg;

  localparam int NUM_SERVOS    = 6;
  localparam int POSITION_BITS = 12;
  localparam int SERVO_W       = 3;
  localparam int EMIT_N        = (NUM_SERVOS < 6) ? NUM_SERVOS : 6;

  localparam int POS_W      = 16;
  localparam int STEP_W     = 10;
  localparam int DZ_W       = 15;
  localparam int TRIG_W     = 10;
  localparam int HAT_W      = 2;
  localparam int LIMREG_W   = 56;
  localparam int LIMREG_N   = 3;
  localparam int MAP_W      = 18;
  localparam int MASK_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 56;
  localparam int PROD_W     = 27;
  localparam int QUO_W      = 17;
  localparam int DELTA_W    = 13;
  localparam int WIDE_W     = 18;

  localparam logic signed [WIDE_W-1:0] SAT_MAX = 18'sd32767;
  localparam logic signed [WIDE_W-1:0] SAT_MIN = -18'sd32768;

  localparam logic [MAP_W-1:0]  CMAP_RST    = 18'd181896;
  localparam logic [MASK_W-1:0] PRESENT_RST = 6'd63;
  localparam logic [MASK_W-1:0] LVALID_RST  = 6'd0;
  localparam logic [STEP_W-1:0] STEP_RST    = 10'd100;
  localparam logic [DZ_W-1:0]   DZ_RST      = 15'd8000;

  localparam logic [HAT_W-1:0] HAT_RIGHT = 2'b01;
  localparam logic [HAT_W-1:0] HAT_LEFT  = 2'b11;

  // control groups in control_map
  localparam int GRP_HAT     = 0;
  localparam int GRP_LSTICK  = 1;
  localparam int GRP_RSTICK  = 2;
  localparam int GRP_BUTTONS = 3;
  localparam int GRP_BUMPERS = 4;
  localparam int GRP_TRIGGER = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIM01   = 3'd0,
    REG_LIM23   = 3'd1,
    REG_LIM45   = 3'd2,
    REG_CMAP    = 3'd3,
    REG_PRESENT = 3'd4,
    REG_LVALID  = 3'd5,
    REG_STEP    = 3'd6,
    REG_DZ      = 3'd7
  } cfg_reg_t;

  typedef logic [LIMREG_N-1:0][LIMREG_W-1:0] lim_regs_t;

  typedef struct packed {
    lim_regs_t          limits;
    logic [MAP_W-1:0]   cmap;
    logic [MASK_W-1:0]  present;
    logic [MASK_W-1:0]  lvalid;
    logic [STEP_W-1:0]  step;
    logic [DZ_W-1:0]    dz;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE  = 5'd0,
    OP_HAT   = 5'd1,
    OP_LMUL  = 5'd2,
    OP_LDIV  = 5'd3,
    OP_LADD  = 5'd4,
    OP_RMUL  = 5'd5,
    OP_RDIV  = 5'd6,
    OP_RADD  = 5'd7,
    OP_WEST  = 5'd8,
    OP_SOUTH = 5'd9,
    OP_BL    = 5'd10,
    OP_BR    = 5'd11,
    OP_TMUL  = 5'd12,
    OP_TDIV  = 5'd13,
    OP_TSET  = 5'd14,
    OP_CLAMP = 5'd15,
    OP_STOP  = 5'd16
  } dp_op_t;

  typedef struct packed {
    dp_op_t             op;
    logic               capture;
    logic               preset;
    logic               emit;
    logic               last;
    logic [SERVO_W-1:0] idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  function automatic logic [SERVO_W-1:0] map_target(input logic [MAP_W-1:0] cmap,
                                                    input int grp);
    return cmap[grp*SERVO_W +: SERVO_W];
  endfunction

  function automatic logic servo_ok(input logic [SERVO_W-1:0] s);
    return int'(s) < NUM_SERVOS;
  endfunction

  function automatic logic limits_ok(input logic [MASK_W-1:0] lvalid,
                                     input logic [SERVO_W-1:0] s);
    return servo_ok(s) && (int'(s) < MASK_W) && lvalid[s];
  endfunction

  function automatic logic [POSITION_BITS-1:0] lim_value(input lim_regs_t lims,
                                                         input logic [SERVO_W-1:0] s,
                                                         input logic upper);
    logic [1:0] pidx;
    int         base;
    pidx = (s[2:1] == 2'd3) ? 2'd0 : s[2:1];
    base = (s[0] ? 32 : 0) + (upper ? POSITION_BITS : 0);
    return lims[pidx][base +: POSITION_BITS];
  endfunction

  function automatic logic signed [POS_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] t;
    t = v;
    if (t > SAT_MAX) begin
      t = SAT_MAX;
    end else if (t < SAT_MIN) begin
      t = SAT_MIN;
    end
    return t[POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gamepad_servo_jog_integrator_core.sv =====
// ----------------------------------------------------------------------------
// gamepad_servo_jog_integrator_core
// Six servo position accumulators jogged by gamepad ticks, clamped to
// per-servo limits, one position command per present servo.
// ----------------------------------------------------------------------------
// A preset item emits nothing. A tick steps through accept, then hat, two
// sticks at three steps each, four button steps and three trigger steps
// through the stick and trigger multipliers and constant dividers, then a
// clamp and emit step per servo; a stalled output holds the emit walk.
// A start press emits one stopped item and halts further ticks for good.
`default_nettype none

module gamepad_servo_jog_integrator_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [gsji_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [gsji_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_operation,
  input  wire logic signed [gsji_pkg::HAT_W-1:0]    in_hat_x,
  input  wire logic signed [gsji_pkg::POS_W-1:0]    in_left_stick_y,
  input  wire logic signed [gsji_pkg::POS_W-1:0]    in_right_stick_y,
  input  wire logic                                 in_button_west,
  input  wire logic                                 in_button_south,
  input  wire logic                                 in_bumper_left,
  input  wire logic                                 in_bumper_right,
  input  wire logic [gsji_pkg::TRIG_W-1:0]          in_trigger_right,
  input  wire logic                                 in_button_start,
  input  wire logic [gsji_pkg::SERVO_W-1:0]         in_preset_servo,
  input  wire logic signed [gsji_pkg::POS_W-1:0]    in_preset_position,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [gsji_pkg::SERVO_W-1:0]              out_servo_number,
  output logic signed [gsji_pkg::POS_W-1:0]         out_commanded_position,
  output logic                                      out_stopped,
  output logic                                      out_last_of_tick
);

  gsji_pkg::cfg_t       cfg;
  gsji_pkg::ctrl_cmd_t  cmd;
  gsji_pkg::dp_status_t sts;

  gsji_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gsji_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .sts             (sts),
    .in_valid        (in_valid),
    .in_operation    (in_operation),
    .in_button_start (in_button_start),
    .in_stall        (in_stall),
    .cmd             (cmd)
  );

  gsji_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg),
    .cmd                    (cmd),
    .sts                    (sts),
    .in_hat_x               (in_hat_x),
    .in_left_stick_y        (in_left_stick_y),
    .in_right_stick_y       (in_right_stick_y),
    .in_button_west         (in_button_west),
    .in_button_south        (in_button_south),
    .in_bumper_left         (in_bumper_left),
    .in_bumper_right        (in_bumper_right),
    .in_trigger_right       (in_trigger_right),
    .in_preset_servo        (in_preset_servo),
    .in_preset_position     (in_preset_position),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_servo_number       (out_servo_number),
    .out_commanded_position (out_commanded_position),
    .out_stopped            (out_stopped),
    .out_last_of_tick       (out_last_of_tick)
  );

endmodule

`default_nettype wire

// ===== rtl/gsji_cfg.sv =====
// ----------------------------------------------------------------------------
// gsji_cfg
// Configuration register file: limits, control map, masks, step, dead zone.
// ----------------------------------------------------------------------------
`default_nettype none

module gsji_cfg (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [gsji_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [gsji_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output gsji_pkg::cfg_t                            cfg
);

  gsji_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.limits  <= '0;
      cfg_r.cmap    <= gsji_pkg::CMAP_RST;
      cfg_r.present <= gsji_pkg::PRESENT_RST;
      cfg_r.lvalid  <= gsji_pkg::LVALID_RST;
      cfg_r.step    <= gsji_pkg::STEP_RST;
      cfg_r.dz      <= gsji_pkg::DZ_RST;
    end else if (cfg_we) begin
      case (gsji_pkg::cfg_reg_t'(cfg_index))
        gsji_pkg::REG_LIM01:   cfg_r.limits[0] <= cfg_wdata[gsji_pkg::LIMREG_W-1:0];
        gsji_pkg::REG_LIM23:   cfg_r.limits[1] <= cfg_wdata[gsji_pkg::LIMREG_W-1:0];
        gsji_pkg::REG_LIM45:   cfg_r.limits[2] <= cfg_wdata[gsji_pkg::LIMREG_W-1:0];
        gsji_pkg::REG_CMAP:    cfg_r.cmap      <= cfg_wdata[gsji_pkg::MAP_W-1:0];
        gsji_pkg::REG_PRESENT: cfg_r.present   <= cfg_wdata[gsji_pkg::MASK_W-1:0];
        gsji_pkg::REG_LVALID:  cfg_r.lvalid    <= cfg_wdata[gsji_pkg::MASK_W-1:0];
        gsji_pkg::REG_STEP:    cfg_r.step      <= cfg_wdata[gsji_pkg::STEP_W-1:0];
        gsji_pkg::REG_DZ:      cfg_r.dz        <= cfg_wdata[gsji_pkg::DZ_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/gsji_dp.sv =====
// ----------------------------------------------------------------------------
// gsji_dp
// Datapath: position accumulators, stick and trigger multipliers, constant dividers,
// saturation, clamp and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gsji_dp (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  gsji_pkg::cfg_t                              cfg,
  input  gsji_pkg::ctrl_cmd_t                         cmd,
  output gsji_pkg::dp_status_t                        sts,
  input  wire logic signed [gsji_pkg::HAT_W-1:0]      in_hat_x,
  input  wire logic signed [gsji_pkg::POS_W-1:0]      in_left_stick_y,
  input  wire logic signed [gsji_pkg::POS_W-1:0]      in_right_stick_y,
  input  wire logic                                   in_button_west,
  input  wire logic                                   in_button_south,
  input  wire logic                                   in_bumper_left,
  input  wire logic                                   in_bumper_right,
  input  wire logic [gsji_pkg::TRIG_W-1:0]            in_trigger_right,
  input  wire logic [gsji_pkg::SERVO_W-1:0]           in_preset_servo,
  input  wire logic signed [gsji_pkg::POS_W-1:0]      in_preset_position,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [gsji_pkg::SERVO_W-1:0]                out_servo_number,
  output logic signed [gsji_pkg::POS_W-1:0]           out_commanded_position,
  output logic                                        out_stopped,
  output logic                                        out_last_of_tick
);

  localparam int PB = gsji_pkg::POSITION_BITS;

  logic signed [gsji_pkg::POS_W-1:0] pos_r [gsji_pkg::NUM_SERVOS];

  logic [gsji_pkg::HAT_W-1:0]         hat_r;
  logic signed [gsji_pkg::POS_W-1:0]  lsy_r;
  logic signed [gsji_pkg::POS_W-1:0]  rsy_r;
  logic                               west_r;
  logic                               south_r;
  logic                               bl_r;
  logic                               br_r;
  logic [gsji_pkg::TRIG_W-1:0]        trig_r;
  logic [gsji_pkg::PROD_W-1:0]        prod_r;
  logic [gsji_pkg::QUO_W-1:0]         q_r;
  logic                               tneg_r;

  logic                                out_valid_r;
  logic [gsji_pkg::SERVO_W-1:0]        out_num_r;
  logic signed [gsji_pkg::POS_W-1:0]   out_pos_r;
  logic                                out_stop_r;
  logic                                out_last_r;

  logic [gsji_pkg::SERVO_W-1:0]        sel;
  logic signed [gsji_pkg::POS_W-1:0]   rd;
  logic [PB-1:0]                       up_v;
  logic [PB-1:0]                       lo_v;
  logic signed [gsji_pkg::WIDE_W-1:0]  up_w;
  logic signed [gsji_pkg::WIDE_W-1:0]  lo_w;

  logic signed [gsji_pkg::POS_W-1:0]   stick;
  logic signed [gsji_pkg::POS_W:0]     stick17;
  logic signed [gsji_pkg::POS_W:0]     mag17;
  logic signed [gsji_pkg::POS_W-1:0]   vz;
  logic [gsji_pkg::POS_W-1:0]          off;
  logic [gsji_pkg::PROD_W-1:0]         prod_stick;
  logic signed [PB:0]                  ldiff;
  logic signed [PB:0]                  labs;
  logic [gsji_pkg::PROD_W-1:0]         prod_trig;

  logic [10:0]                         sq0;
  logic [gsji_pkg::QUO_W-1:0]          srem;
  logic [gsji_pkg::QUO_W-1:0]          squo;
  logic [gsji_pkg::PROD_W:0]           tsum;
  logic [gsji_pkg::PROD_W:0]           trem;
  logic [gsji_pkg::QUO_W-1:0]          tquo;
  logic signed [gsji_pkg::WIDE_W-1:0]  tval;

  logic signed [gsji_pkg::DELTA_W-1:0] delta;
  logic signed [gsji_pkg::DELTA_W-1:0] step_s;
  logic signed [gsji_pkg::DELTA_W-1:0] half_s;
  logic signed [gsji_pkg::WIDE_W-1:0]  csum;
  logic signed [gsji_pkg::WIDE_W-1:0]  cval;
  logic signed [gsji_pkg::POS_W-1:0]   wval;
  logic                                wen;
  logic                                load;

  // target servo per operation
  always_comb begin
    case (cmd.op)
      gsji_pkg::OP_HAT:   sel = gsji_pkg::map_target(cfg.cmap, gsji_pkg::GRP_HAT);
      gsji_pkg::OP_LADD:  sel = gsji_pkg::map_target(cfg.cmap, gsji_pkg::GRP_LSTICK);
      gsji_pkg::OP_RADD:  sel = gsji_pkg::map_target(cfg.cmap, gsji_pkg::GRP_RSTICK);
      gsji_pkg::OP_WEST,
      gsji_pkg::OP_SOUTH: sel = gsji_pkg::map_target(cfg.cmap, gsji_pkg::GRP_BUTTONS);
      gsji_pkg::OP_BL,
      gsji_pkg::OP_BR:    sel = gsji_pkg::map_target(cfg.cmap, gsji_pkg::GRP_BUMPERS);
      gsji_pkg::OP_TMUL,
      gsji_pkg::OP_TSET:  sel = gsji_pkg::map_target(cfg.cmap, gsji_pkg::GRP_TRIGGER);
      gsji_pkg::OP_CLAMP: sel = cmd.idx;
      default:            sel = '0;
    endcase
  end

  assign rd   = gsji_pkg::servo_ok(sel) ? pos_r[sel] : '0;
  assign up_v = gsji_pkg::lim_value(cfg.limits, sel, 1'b1);
  assign lo_v = gsji_pkg::lim_value(cfg.limits, sel, 1'b0);
  assign up_w = $signed(gsji_pkg::WIDE_W'(up_v));
  assign lo_w = $signed(gsji_pkg::WIDE_W'(lo_v));

  // multiply operands
  always_comb begin
    stick      = (cmd.op == gsji_pkg::OP_RMUL) ? rsy_r : lsy_r;
    stick17    = {stick[gsji_pkg::POS_W-1], stick};
    mag17      = stick17[gsji_pkg::POS_W] ? -stick17 : stick17;
    vz         = (mag17 < $signed({2'b00, cfg.dz})) ? '0 : stick;
    off        = {~vz[gsji_pkg::POS_W-1], vz[gsji_pkg::POS_W-2:0]};
    prod_stick = gsji_pkg::PROD_W'(off) * gsji_pkg::PROD_W'({cfg.step, 1'b0});
    ldiff      = $signed({1'b0, lo_v}) - $signed({1'b0, up_v});
    labs       = ldiff[PB] ? -ldiff : ldiff;
    prod_trig  = gsji_pkg::PROD_W'(trig_r) * gsji_pkg::PROD_W'(labs[PB-1:0]);
  end

  // divide by 65535 and by 1023
  always_comb begin
    sq0  = prod_r[gsji_pkg::PROD_W-1:16];
    srem = gsji_pkg::QUO_W'(prod_r[15:0]) + gsji_pkg::QUO_W'(sq0);
    squo = gsji_pkg::QUO_W'(sq0) + gsji_pkg::QUO_W'(srem >= 17'd65535);
    tsum = (gsji_pkg::PROD_W+1)'(prod_r) + (gsji_pkg::PROD_W+1)'(prod_r >> 10)
         + (gsji_pkg::PROD_W+1)'(prod_r >> 20);
    trem = (gsji_pkg::PROD_W+1)'(prod_r) + (gsji_pkg::PROD_W+1)'(q_r)
         - ((gsji_pkg::PROD_W+1)'(q_r) << 10);
    tquo = q_r + gsji_pkg::QUO_W'(trem >= 28'd1023);
    tval = tneg_r ? -$signed(gsji_pkg::WIDE_W'(tquo)) : $signed(gsji_pkg::WIDE_W'(tquo));
  end

  // write value
  always_comb begin
    step_s = $signed(gsji_pkg::DELTA_W'(cfg.step));
    half_s = $signed(gsji_pkg::DELTA_W'(cfg.step >> 1));
    case (cmd.op)
      gsji_pkg::OP_HAT: begin
        if (hat_r == gsji_pkg::HAT_RIGHT) begin
          delta = half_s;
        end else if (hat_r == gsji_pkg::HAT_LEFT) begin
          delta = -half_s;
        end else begin
          delta = '0;
        end
      end
      gsji_pkg::OP_LADD,
      gsji_pkg::OP_RADD:  delta = $signed(gsji_pkg::DELTA_W'(q_r)) - step_s;
      gsji_pkg::OP_WEST:  delta = west_r  ? -step_s : '0;
      gsji_pkg::OP_SOUTH: delta = south_r ? step_s  : '0;
      gsji_pkg::OP_BL:    delta = bl_r    ? step_s  : '0;
      gsji_pkg::OP_BR:    delta = br_r    ? -step_s : '0;
      default:            delta = '0;
    endcase
    csum = gsji_pkg::WIDE_W'(rd) + gsji_pkg::WIDE_W'(delta);

    cval = gsji_pkg::WIDE_W'(rd);
    if (gsji_pkg::limits_ok(cfg.lvalid, sel)) begin
      if (cval > up_w) begin
        cval = up_w;
      end
      if (cval < lo_w) begin
        cval = lo_w;
      end
    end

    case (cmd.op)
      gsji_pkg::OP_HAT, gsji_pkg::OP_LADD, gsji_pkg::OP_RADD, gsji_pkg::OP_WEST,
      gsji_pkg::OP_SOUTH, gsji_pkg::OP_BL, gsji_pkg::OP_BR: begin
        wval = gsji_pkg::sat16(csum);
        wen  = gsji_pkg::servo_ok(sel);
      end
      gsji_pkg::OP_TSET: begin
        wval = gsji_pkg::sat16(tval + up_w);
        wen  = gsji_pkg::limits_ok(cfg.lvalid, sel);
      end
      gsji_pkg::OP_CLAMP: begin
        wval = gsji_pkg::sat16(cval);
        wen  = 1'b1;
      end
      default: begin
        wval = '0;
        wen  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gsji_pkg::NUM_SERVOS; i++) begin
        pos_r[i] <= '0;
      end
    end else if (cmd.preset) begin
      if (gsji_pkg::servo_ok(in_preset_servo)) begin
        pos_r[in_preset_servo] <= in_preset_position;
      end
    end else if (wen) begin
      pos_r[sel] <= wval;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hat_r   <= in_hat_x;
      lsy_r   <= in_left_stick_y;
      rsy_r   <= in_right_stick_y;
      west_r  <= in_button_west;
      south_r <= in_button_south;
      bl_r    <= in_bumper_left;
      br_r    <= in_bumper_right;
      trig_r  <= in_trigger_right;
    end
    case (cmd.op)
      gsji_pkg::OP_LMUL,
      gsji_pkg::OP_RMUL: prod_r <= prod_stick;
      gsji_pkg::OP_TMUL: begin
        prod_r <= prod_trig;
        tneg_r <= ldiff[PB];
      end
      gsji_pkg::OP_LDIV,
      gsji_pkg::OP_RDIV: q_r <= squo;
      gsji_pkg::OP_TDIV: q_r <= tsum[gsji_pkg::QUO_W+9:10];
      default: ;
    endcase
  end

  // output register
  assign load         = ((cmd.op == gsji_pkg::OP_CLAMP) && cmd.emit)
                      || (cmd.op == gsji_pkg::OP_STOP);
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (cmd.op == gsji_pkg::OP_STOP) begin
        out_num_r  <= '0;
        out_pos_r  <= '0;
        out_stop_r <= 1'b1;
        out_last_r <= 1'b1;
      end else begin
        out_num_r  <= cmd.idx;
        out_pos_r  <= wval;
        out_stop_r <= 1'b0;
        out_last_r <= cmd.last;
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_servo_number       = out_num_r;
  assign out_commanded_position = out_pos_r;
  assign out_stopped            = out_stop_r;
  assign out_last_of_tick       = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/gsji_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsji_ctrl
// Sequencer: accepts items, steps the datapath through one tick, walks the
// servos for clamp and emit, and keeps the halted flag.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gamepad_servo_jog_integrator_core_macros.svh"

module gsji_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  gsji_pkg::cfg_t        cfg,
  input  gsji_pkg::dp_status_t  sts,
  input  wire logic             in_valid,
  input  wire logic             in_operation,
  input  wire logic             in_button_start,
  output logic                  in_stall,
  output gsji_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [16:0] {
    ST_IDLE  = 17'h00001,
    ST_HAT   = 17'h00002,
    ST_LMUL  = 17'h00004,
    ST_LDIV  = 17'h00008,
    ST_LADD  = 17'h00010,
    ST_RMUL  = 17'h00020,
    ST_RDIV  = 17'h00040,
    ST_RADD  = 17'h00080,
    ST_WEST  = 17'h00100,
    ST_SOUTH = 17'h00200,
    ST_BL    = 17'h00400,
    ST_BR    = 17'h00800,
    ST_TMUL  = 17'h01000,
    ST_TDIV  = 17'h02000,
    ST_TSET  = 17'h04000,
    ST_EMIT  = 17'h08000,
    ST_STOP  = 17'h10000
  } state_t;

  state_t                             state_r, state_nxt;
  logic [gsji_pkg::SERVO_W-1:0]       idx_r, idx_nxt;
  logic                               halted_r, halted_nxt;
  logic                               present_i;
  logic [gsji_pkg::MASK_W-1:0]        above;
  logic                               last_i;

  assign present_i = cfg.present[idx_r];
  assign above     = cfg.present >> ({1'b0, idx_r} + 4'd1);
  assign last_i    = present_i && (above == '0);

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    halted_nxt  = halted_r;
    in_stall    = (state_r != ST_IDLE);
    cmd         = '0;
    cmd.op      = gsji_pkg::OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_operation) begin
            cmd.preset = 1'b1;
          end else if (!halted_r) begin
            if (in_button_start) begin
              halted_nxt = 1'b1;
              state_nxt  = ST_STOP;
            end else begin
              cmd.capture = 1'b1;
              state_nxt   = ST_HAT;
            end
          end
        end
      end
      ST_HAT: begin
        cmd.op    = gsji_pkg::OP_HAT;
        state_nxt = ST_LMUL;
      end
      ST_LMUL: begin
        cmd.op    = gsji_pkg::OP_LMUL;
        state_nxt = ST_LDIV;
      end
      ST_LDIV: begin
        cmd.op    = gsji_pkg::OP_LDIV;
        state_nxt = ST_LADD;
      end
      ST_LADD: begin
        cmd.op    = gsji_pkg::OP_LADD;
        state_nxt = ST_RMUL;
      end
      ST_RMUL: begin
        cmd.op    = gsji_pkg::OP_RMUL;
        state_nxt = ST_RDIV;
      end
      ST_RDIV: begin
        cmd.op    = gsji_pkg::OP_RDIV;
        state_nxt = ST_RADD;
      end
      ST_RADD: begin
        cmd.op    = gsji_pkg::OP_RADD;
        state_nxt = ST_WEST;
      end
      ST_WEST: begin
        cmd.op    = gsji_pkg::OP_WEST;
        state_nxt = ST_SOUTH;
      end
      ST_SOUTH: begin
        cmd.op    = gsji_pkg::OP_SOUTH;
        state_nxt = ST_BL;
      end
      ST_BL: begin
        cmd.op    = gsji_pkg::OP_BL;
        state_nxt = ST_BR;
      end
      ST_BR: begin
        cmd.op    = gsji_pkg::OP_BR;
        state_nxt = ST_TMUL;
      end
      ST_TMUL: begin
        cmd.op    = gsji_pkg::OP_TMUL;
        state_nxt = ST_TDIV;
      end
      ST_TDIV: begin
        cmd.op    = gsji_pkg::OP_TDIV;
        state_nxt = ST_TSET;
      end
      ST_TSET: begin
        cmd.op    = gsji_pkg::OP_TSET;
        idx_nxt   = '0;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.idx  = idx_r;
        cmd.last = last_i;
        if (!present_i || sts.out_free) begin
          cmd.op   = gsji_pkg::OP_CLAMP;
          cmd.emit = present_i;
          if (int'(idx_r) == gsji_pkg::EMIT_N - 1) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_STOP: begin
        if (sts.out_free) begin
          cmd.op    = gsji_pkg::OP_STOP;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      idx_r    <= '0;
      halted_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      halted_r <= halted_nxt;
    end
  end

  `ASSERT_IMPL(a_emit_needs_room, clk, rst_n, cmd.emit, sts.out_free)
  `ASSERT_NEXT(a_halt_sticky, clk, rst_n, halted_r, halted_r)
  `ASSERT_IMPL(a_idx_range, clk, rst_n, state_r == ST_EMIT, int'(idx_r) < gsji_pkg::EMIT_N)
  `ASSERT_IMPL(a_no_tick_halted, clk, rst_n, cmd.capture, !halted_r)

endmodule

`default_nettype wire

// ===== dv/gamepad_servo_jog_integrator_core_tb.sv =====
// ----------------------------------------------------------------------------
// gamepad_servo_jog_integrator_core_tb
// Self-checking bench for the servo jog integrator. Presets and gamepad ticks
// go in under random input idling and output stalls. A scoreboard keeps its
// own copy of the six accumulators and the registers, predicts every servo
// command per tick, and checks each command in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module gamepad_servo_jog_integrator_core_tb;
  import gsji_pkg::*;

  localparam int  CYCLE_LIMIT   = 300000;
  localparam int  SETTLE_CYCLES = 40;
  localparam int  END_CYCLES    = 60;
  localparam int  HOLD_CYCLES   = 400;
  localparam logic ITEM_TICK    = 1'b0;
  localparam logic ITEM_PRESET  = 1'b1;

  typedef struct packed {
    logic                     operation;
    logic signed [HAT_W-1:0]  hat_x;
    logic signed [POS_W-1:0]  left_stick_y;
    logic signed [POS_W-1:0]  right_stick_y;
    logic                     button_west;
    logic                     button_south;
    logic                     bumper_left;
    logic                     bumper_right;
    logic [TRIG_W-1:0]        trigger_right;
    logic                     button_start;
    logic [SERVO_W-1:0]       preset_servo;
    logic signed [POS_W-1:0]  preset_position;
  } jog_item_t;

  typedef struct packed {
    logic [SERVO_W-1:0]       servo;
    logic signed [POS_W-1:0]  position;
    logic                     stopped;
    logic                     last;
  } servo_cmd_t;

  class servo_jog_scoreboard;
    cfg_t       cfg;
    int         pos [NUM_SERVOS];
    bit         halted;
    servo_cmd_t expected_q [$];
    int         errors;
    int         n_seen;

    function new();
      cfg.limits  = '0;
      cfg.cmap    = CMAP_RST;
      cfg.present = PRESENT_RST;
      cfg.lvalid  = LVALID_RST;
      cfg.step    = STEP_RST;
      cfg.dz      = DZ_RST;
      foreach (pos[i]) pos[i] = 0;
      halted = 1'b0;
      errors = 0;
      n_seen = 0;
    endfunction

    function void write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
      case (r)
        REG_LIM01:   cfg.limits[0] = v;
        REG_LIM23:   cfg.limits[1] = v;
        REG_LIM45:   cfg.limits[2] = v;
        REG_CMAP:    cfg.cmap      = v[MAP_W-1:0];
        REG_PRESENT: cfg.present   = v[MASK_W-1:0];
        REG_LVALID:  cfg.lvalid    = v[MASK_W-1:0];
        REG_STEP:    cfg.step      = v[STEP_W-1:0];
        REG_DZ:      cfg.dz        = v[DZ_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int target(int grp);
      int s;
      s = int'(cfg.cmap[grp*SERVO_W +: SERVO_W]);
      return (s < NUM_SERVOS) ? s : -1;
    endfunction

    function bit has_limits(int s);
      return (s >= 0) && (s < NUM_SERVOS) && (s < MASK_W) && cfg.lvalid[s];
    endfunction

    function int limit(int s, bit upper);
      logic [LIMREG_W-1:0] r;
      r = cfg.limits[(s >> 1) % LIMREG_N];
      return int'(r[(s % 2) * 32 + (upper ? POSITION_BITS : 0) +: POSITION_BITS]);
    endfunction

    function int saturate(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
    endfunction

    function void nudge(int s, longint d);
      if (s >= 0) pos[s] = saturate(longint'(pos[s]) + d);
    endfunction

    function longint stick_move(int v);
      longint st;
      int     mag;
      st  = cfg.step;
      mag = (v < 0) ? -v : v;
      if (mag < int'(cfg.dz)) v = 0;
      return ((longint'(v) + 32768) * (2 * st)) / 65535 - st;
    endfunction

    function void note_item(jog_item_t it);
      longint     st;
      int         s, up, lo, n;
      servo_cmd_t c;
      if (it.operation == ITEM_PRESET) begin
        if (it.preset_servo < NUM_SERVOS) pos[it.preset_servo] = it.preset_position;
        return;
      end
      if (halted) return;
      if (it.button_start) begin
        halted = 1'b1;
        c.servo = '0;
        c.position = '0;
        c.stopped = 1'b1;
        c.last = 1'b1;
        expected_q.push_back(c);
        return;
      end
      st = cfg.step;
      s = target(GRP_HAT);
      if (it.hat_x == HAT_RIGHT) nudge(s, st / 2);
      else if (it.hat_x == HAT_LEFT) nudge(s, -(st / 2));
      nudge(target(GRP_LSTICK), stick_move(it.left_stick_y));
      nudge(target(GRP_RSTICK), stick_move(it.right_stick_y));
      s = target(GRP_BUTTONS);
      if (it.button_west) nudge(s, -st);
      if (it.button_south) nudge(s, st);
      s = target(GRP_BUMPERS);
      if (it.bumper_left) nudge(s, st);
      if (it.bumper_right) nudge(s, -st);
      s = target(GRP_TRIGGER);
      if (has_limits(s)) begin
        up = limit(s, 1'b1);
        lo = limit(s, 1'b0);
        pos[s] = saturate(longint'(it.trigger_right) * (lo - up) / 1023 + up);
      end
      n = 0;
      for (int i = 0; i < NUM_SERVOS; i++) begin
        if (has_limits(i)) begin
          up = limit(i, 1'b1);
          lo = limit(i, 1'b0);
          if (pos[i] > up) pos[i] = up;
          if (pos[i] < lo) pos[i] = lo;
        end
        if (cfg.present[i]) begin
          c.servo = i;
          c.position = pos[i];
          c.stopped = 1'b0;
          c.last = 1'b0;
          expected_q.push_back(c);
          n++;
        end
      end
      if (n > 0) expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    function void check_result(servo_cmd_t got);
      servo_cmd_t want;
      n_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR cmd %0d unexpected: servo %0d pos %0d stopped %0b last %0b",
                   n_seen, got.servo, got.position, got.stopped, got.last);
        return;
      end
      want = expected_q.pop_front();
      if (got.servo !== want.servo || got.position !== want.position ||
          got.stopped !== want.stopped || got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("ERROR cmd %0d: exp servo %0d pos %0d stopped %0b last %0b, got servo %0d pos %0d stopped %0b last %0b",
                   n_seen, want.servo, want.position, want.stopped, want.last,
                   got.servo, got.position, got.stopped, got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic in_operation;
  logic signed [HAT_W-1:0] in_hat_x;
  logic signed [POS_W-1:0] in_left_stick_y;
  logic signed [POS_W-1:0] in_right_stick_y;
  logic in_button_west;
  logic in_button_south;
  logic in_bumper_left;
  logic in_bumper_right;
  logic [TRIG_W-1:0] in_trigger_right;
  logic in_button_start;
  logic [SERVO_W-1:0] in_preset_servo;
  logic signed [POS_W-1:0] in_preset_position;
  logic out_valid;
  logic out_stall;
  logic [SERVO_W-1:0] out_servo_number;
  logic signed [POS_W-1:0] out_commanded_position;
  logic out_stopped;
  logic out_last_of_tick;

  servo_jog_scoreboard sb = new();
  int cycles = 0;
  int hold_requests = 0;
  bit rx_steady = 1'b0;
  bit tx_steady = 1'b0;

  gamepad_servo_jog_integrator_core dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_operation           (in_operation),
    .in_hat_x               (in_hat_x),
    .in_left_stick_y        (in_left_stick_y),
    .in_right_stick_y       (in_right_stick_y),
    .in_button_west         (in_button_west),
    .in_button_south        (in_button_south),
    .in_bumper_left         (in_bumper_left),
    .in_bumper_right        (in_bumper_right),
    .in_trigger_right       (in_trigger_right),
    .in_button_start        (in_button_start),
    .in_preset_servo        (in_preset_servo),
    .in_preset_position     (in_preset_position),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_servo_number       (out_servo_number),
    .out_commanded_position (out_commanded_position),
    .out_stopped            (out_stopped),
    .out_last_of_tick       (out_last_of_tick)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("gamepad_servo_jog_integrator_core_tb: done, errors");
      $finish;
    end
  end

  // output side: random stalls, quiet stretches and long hold-offs on request
  initial begin
    int hold_left;
    int holds_taken;
    hold_left = 0;
    holds_taken = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_taken != hold_requests) begin
        holds_taken++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_steady) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 18);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_servo_number, out_commanded_position, out_stopped,
                       out_last_of_tick});
  end

  function automatic jog_item_t make_tick(logic signed [HAT_W-1:0] hat,
                                          logic signed [POS_W-1:0] ly,
                                          logic signed [POS_W-1:0] ry,
                                          logic [3:0] btns, logic [TRIG_W-1:0] trig,
                                          logic start);
    jog_item_t it;
    it = '0;
    it.operation = ITEM_TICK;
    it.hat_x = hat;
    it.left_stick_y = ly;
    it.right_stick_y = ry;
    {it.button_west, it.button_south, it.bumper_left, it.bumper_right} = btns;
    it.trigger_right = trig;
    it.button_start = start;
    return it;
  endfunction

  function automatic jog_item_t make_preset(logic [SERVO_W-1:0] servo,
                                            logic signed [POS_W-1:0] position);
    jog_item_t it;
    it = '0;
    it.operation = ITEM_PRESET;
    it.preset_servo = servo;
    it.preset_position = position;
    return it;
  endfunction

  function automatic logic signed [POS_W-1:0] near_dead_zone(int dz);
    int v;
    v = dz + $urandom_range(2) - 1;
    if ($urandom_range(1)) v = -v;
    return v[POS_W-1:0];
  endfunction

  function automatic jog_item_t random_item(int dz, bit ticks_only);
    jog_item_t it;
    it = {$urandom, $urandom, $urandom};
    it.button_start = 1'b0;
    it.operation = (!ticks_only && $urandom_range(99) < 20) ? ITEM_PRESET : ITEM_TICK;
    if ($urandom_range(2) == 0) it.left_stick_y = near_dead_zone(dz);
    if ($urandom_range(2) == 0) it.right_stick_y = near_dead_zone(dz);
    if ($urandom_range(9) == 0) it.trigger_right = $urandom_range(1) ? '1 : '0;
    if ($urandom_range(9) == 0) it.preset_position = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    return it;
  endfunction

  function automatic logic [LIMREG_W-1:0] pack_limits(int lo0, int up0, int lo1, int up1);
    logic [LIMREG_W-1:0] r;
    r = '0;
    r[0 +: POSITION_BITS] = lo0;
    r[POSITION_BITS +: POSITION_BITS] = up0;
    r[32 +: POSITION_BITS] = lo1;
    r[32 + POSITION_BITS +: POSITION_BITS] = up1;
    return r;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    for (int k = 0; k < LIMREG_N; k++) c.limits[k] = {$urandom, $urandom};
    c.cmap = $urandom;
    c.present = $urandom_range(1, 63);
    c.lvalid = $urandom;
    c.step = $urandom_range(1023);
    c.dz = ($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(12000);
    return c;
  endfunction

  task automatic send_item(jog_item_t it);
    int gap;
    gap = 0;
    if (!tx_steady && $urandom_range(99) < 18) gap = $urandom_range(1, 25);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_operation       <= it.operation;
    in_hat_x           <= it.hat_x;
    in_left_stick_y    <= it.left_stick_y;
    in_right_stick_y   <= it.right_stick_y;
    in_button_west     <= it.button_west;
    in_button_south    <= it.button_south;
    in_bumper_left     <= it.bumper_left;
    in_bumper_right    <= it.bumper_right;
    in_trigger_right   <= it.trigger_right;
    in_button_start    <= it.button_start;
    in_preset_servo    <= it.preset_servo;
    in_preset_position <= it.preset_position;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
  endtask

  // drain all commands, then give a no-output item time to finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(r, v);
  endtask

  task automatic apply_config(cfg_t c);
    wait_idle();
    program_reg(REG_LIM01, c.limits[0]);
    program_reg(REG_LIM23, c.limits[1]);
    program_reg(REG_LIM45, c.limits[2]);
    program_reg(REG_CMAP, c.cmap);
    program_reg(REG_PRESENT, c.present);
    program_reg(REG_LVALID, c.lvalid);
    program_reg(REG_STEP, c.step);
    program_reg(REG_DZ, c.dz);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int count);
    repeat (count) send_item(random_item(int'(sb.cfg.dz), 1'b0));
  endtask

  initial begin
    cfg_t c;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_LIM01;
    cfg_wdata          <= '0;
    in_valid           <= 1'b0;
    in_operation       <= ITEM_TICK;
    in_hat_x           <= '0;
    in_left_stick_y    <= '0;
    in_right_stick_y   <= '0;
    in_button_west     <= 1'b0;
    in_button_south    <= 1'b0;
    in_bumper_left     <= 1'b0;
    in_bumper_right    <= 1'b0;
    in_trigger_right   <= '0;
    in_button_start    <= 1'b0;
    in_preset_servo    <= '0;
    in_preset_position <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: identity map, no limits, all servos present
    send_item(make_preset(0, 16'sh7fff));
    send_item(make_preset(1, 16'sh8000));
    send_item(make_preset(6, 16'sd123));
    send_item(make_preset(7, -16'sd1));
    send_item(make_tick(HAT_RIGHT, 16'sh8000, 16'sd0, 4'b0000, '0, 1'b0));
    send_item(make_tick(HAT_LEFT, 16'sh7fff, 16'sh8000, 4'b0000, '0, 1'b0));
    send_item(make_tick(2'sb10, 16'sd7999, 16'sd8000, 4'b0000, '0, 1'b0));
    send_item(make_tick(2'sb00, -16'sd7999, -16'sd8000, 4'b0000, '0, 1'b0));
    send_item(make_tick(2'sb00, 16'sd0, 16'sd0, 4'b1000, '0, 1'b0));
    send_item(make_tick(2'sb00, 16'sd0, 16'sd0, 4'b0100, '0, 1'b0));
    send_item(make_tick(2'sb00, 16'sd0, 16'sd0, 4'b1100, '0, 1'b0));
    send_item(make_tick(2'sb00, 16'sd0, 16'sd0, 4'b0010, '0, 1'b0));
    send_item(make_tick(2'sb00, 16'sd0, 16'sd0, 4'b0001, '0, 1'b0));
    send_item(make_tick(2'sb00, 16'sd0, 16'sd0, 4'b0011, '1, 1'b0));
    send_item(make_preset(5, 16'sh7fff));
    send_item(make_preset(4, 16'sh8000));
    send_item(make_tick(2'sb00, 16'sh7fff, 16'sh7fff, 4'b0101, '0, 1'b0));

    // limits on all servos, servo 2 reversed, trigger on servo 5
    c.limits[0] = pack_limits(100, 4000, 0, 4095);
    c.limits[1] = pack_limits(3000, 1000, 4095, 4095);
    c.limits[2] = pack_limits(0, 0, 500, 2500);
    c.cmap = CMAP_RST;
    c.present = PRESENT_RST;
    c.lvalid = '1;
    c.step = STEP_RST;
    c.dz = DZ_RST;
    apply_config(c);
    send_item(make_preset(0, 16'sh8000));
    send_item(make_preset(1, 16'sh7fff));
    send_item(make_tick(2'sb00, 16'sd0, 16'sd0, 4'b0000, '0, 1'b0));
    send_item(make_tick(2'sb00, 16'sd0, 16'sd0, 4'b0000, '1, 1'b0));
    send_item(make_tick(2'sb00, 16'sd0, 16'sd0, 4'b0000, 10'd512, 1'b0));
    send_item(make_tick(HAT_RIGHT, 16'sh8000, 16'sh7fff, 4'b0110, 10'd1, 1'b0));
    send_item(make_tick(HAT_LEFT, 16'sh7fff, 16'sh8000, 4'b1001, 10'd1022, 1'b0));

    // random settings, output held off while the input keeps coming
    apply_config(random_cfg());
    run_random(20);
    hold_requests <= hold_requests + 1;
    tx_steady = 1'b1;
    repeat (24) send_item(random_item(int'(sb.cfg.dz), 1'b1));
    tx_steady = 1'b0;
    wait_idle();
    run_random(16);

    // largest step, no dead zone, every control on servo 0, full limits
    c.limits[0] = pack_limits(0, 4095, 0, 4095);
    c.limits[1] = c.limits[0];
    c.limits[2] = c.limits[0];
    c.cmap = '0;
    c.present = '1;
    c.lvalid = '1;
    c.step = '1;
    c.dz = '0;
    apply_config(c);
    run_random(40);

    // zero step, widest dead zone, controls all unmapped
    c = random_cfg();
    c.cmap = {3'd7, 3'd6, 3'd7, 3'd6, 3'd7, 3'd6} | 18'($urandom);
    c.lvalid = '0;
    c.step = '0;
    c.dz = '1;
    apply_config(c);
    run_random(30);

    // nothing present: ticks emit nothing
    c = random_cfg();
    c.present = '0;
    apply_config(c);
    run_random(15);

    rx_steady <= 1'b1;
    tx_steady = 1'b1;
    apply_config(random_cfg());
    run_random(50);
    rx_steady <= 1'b0;
    tx_steady = 1'b0;

    apply_config(random_cfg());
    run_random(60);

    // reversed limits everywhere
    c = random_cfg();
    for (int k = 0; k < LIMREG_N; k++)
      c.limits[k] = pack_limits($urandom_range(2048, 4095), $urandom_range(0, 2047),
                                $urandom_range(2048, 4095), $urandom_range(0, 2047));
    c.lvalid = '1;
    apply_config(c);
    run_random(50);

    // start press halts; later ticks are dropped, presets still load
    send_item(make_tick(HAT_RIGHT, 16'sh7fff, 16'sh8000, 4'b1111, '1, 1'b1));
    send_item(random_item(int'(sb.cfg.dz), 1'b1));
    send_item(make_preset(2, 16'sd77));
    send_item(make_tick(2'sb00, 16'sd0, 16'sd0, 4'b0000, '0, 1'b1));
    send_item(random_item(int'(sb.cfg.dz), 1'b1));

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("gamepad_servo_jog_integrator_core_tb: done, clean");
    end else begin
      $display("gamepad_servo_jog_integrator_core_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
